// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Clocked on clk, switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, disabled during reset.
`define CSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication form: condition this cycle, consequence next cycle.
`define CSU_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== design/csu_pkg.sv =====
// Shared types, operation codes and lane shift function of the shift unit.
// No dependencies; used by csu_decode, csu_coarse, csu_fine and the top level.
package csu_pkg;

	localparam logic [4:0] MODE_DSLL   = 5'd0;
	localparam logic [4:0] MODE_DSRL   = 5'd1;
	localparam logic [4:0] MODE_DSRA   = 5'd2;
	localparam logic [4:0] MODE_DSLL32 = 5'd3;
	localparam logic [4:0] MODE_DSRL32 = 5'd4;
	localparam logic [4:0] MODE_DSRA32 = 5'd5;
	localparam logic [4:0] MODE_DSLLV  = 5'd6;
	localparam logic [4:0] MODE_DSRLV  = 5'd7;
	localparam logic [4:0] MODE_DSRAV  = 5'd8;
	localparam logic [4:0] MODE_SLL    = 5'd9;
	localparam logic [4:0] MODE_SRL    = 5'd10;
	localparam logic [4:0] MODE_SRA    = 5'd11;
	localparam logic [4:0] MODE_SLLV   = 5'd12;
	localparam logic [4:0] MODE_SRLV   = 5'd13;
	localparam logic [4:0] MODE_SRAV   = 5'd14;
	localparam logic [4:0] MODE_PSLLH  = 5'd15;
	localparam logic [4:0] MODE_PSRLH  = 5'd16;
	localparam logic [4:0] MODE_PSRAH  = 5'd17;
	localparam logic [4:0] MODE_PSLLW  = 5'd18;
	localparam logic [4:0] MODE_PSRLW  = 5'd19;
	localparam logic [4:0] MODE_PSRAW  = 5'd20;
	localparam logic [4:0] MODE_PSLLVW = 5'd21;
	localparam logic [4:0] MODE_PSRLVW = 5'd22;
	localparam logic [4:0] MODE_PSRAVW = 5'd23;
	localparam logic [4:0] MODE_QFSRV  = 5'd24;

	// Width of the funnel window carried from the coarse to the fine stage.
	localparam int unsigned FUN_W = 136;

	typedef enum logic [2:0] {
		CLS_NONE = 3'd0,
		CLS_DW   = 3'd1,
		CLS_W    = 3'd2,
		CLS_PH   = 3'd3,
		CLS_PW   = 3'd4,
		CLS_PVW  = 3'd5,
		CLS_FUN  = 3'd6
	} cls_t;

	typedef enum logic [1:0] {
		KIND_SLL = 2'd0,
		KIND_SRL = 2'd1,
		KIND_SRA = 2'd2
	} kind_t;

	typedef struct packed {
		cls_t       cls;
		kind_t      kind;
		logic [7:0] amt_lo;
		logic [4:0] amt_hi;
	} ctl_t;

	// Shift one dword by n according to its lane layout. Shifting by a
	// then by b gives the same as shifting by a+b in every lane, so the
	// coarse and fine stages both use this.
	function automatic logic [63:0] lane_shift(input logic [63:0] d, input cls_t cls,
			input kind_t kind, input logic [5:0] n);
		logic [63:0] r;
		logic [15:0] h;
		logic [31:0] w;
		r = '0;
		case (cls) inside
			CLS_DW: begin
				case (kind)
					KIND_SLL: r = d << n;
					KIND_SRA: r = 64'($signed(d) >>> n);
					default:  r = d >> n;
				endcase
			end
			CLS_W, CLS_PVW: begin
				w = d[31:0];
				case (kind)
					KIND_SLL: r[31:0] = w << n[4:0];
					KIND_SRA: r[31:0] = 32'($signed(w) >>> n[4:0]);
					default:  r[31:0] = w >> n[4:0];
				endcase
			end
			CLS_PW: begin
				for (int i = 0; i < 2; i++) begin
					w = d[32*i +: 32];
					case (kind)
						KIND_SLL: r[32*i +: 32] = w << n[4:0];
						KIND_SRA: r[32*i +: 32] = 32'($signed(w) >>> n[4:0]);
						default:  r[32*i +: 32] = w >> n[4:0];
					endcase
				end
			end
			CLS_PH: begin
				for (int i = 0; i < 4; i++) begin
					h = d[16*i +: 16];
					case (kind)
						KIND_SLL: r[16*i +: 16] = h << n[3:0];
						KIND_SRA: r[16*i +: 16] = 16'($signed(h) >>> n[3:0]);
						default:  r[16*i +: 16] = h >> n[3:0];
					endcase
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/csu_decode.sv =====
// Operation decoder: mode and amount fields to lane class, kind and amounts.
// Depends on csu_pkg.
module csu_decode (
	input  logic [4:0]    mode,
	input  logic [4:0]    shift_field,
	input  logic [7:0]    sa_amount,
	input  logic [5:0]    rs_low_amt,
	input  logic [4:0]    rs_high_amt,
	output csu_pkg::ctl_t ctl
);
	import csu_pkg::*;

	always_comb begin
		ctl.cls    = CLS_NONE;
		ctl.amt_lo = '0;
		ctl.amt_hi = '0;
		unique case (mode) inside
			MODE_DSLL, MODE_DSRL, MODE_DSRA: begin
				ctl.cls    = CLS_DW;
				ctl.amt_lo = {3'b000, shift_field};
			end
			MODE_DSLL32, MODE_DSRL32, MODE_DSRA32: begin
				ctl.cls    = CLS_DW;
				ctl.amt_lo = {3'b001, shift_field};
			end
			MODE_DSLLV, MODE_DSRLV, MODE_DSRAV: begin
				ctl.cls    = CLS_DW;
				ctl.amt_lo = {2'b00, rs_low_amt};
			end
			MODE_SLL, MODE_SRL, MODE_SRA: begin
				ctl.cls    = CLS_W;
				ctl.amt_lo = {3'b000, shift_field};
			end
			MODE_SLLV, MODE_SRLV, MODE_SRAV: begin
				ctl.cls    = CLS_W;
				ctl.amt_lo = {3'b000, rs_low_amt[4:0]};
			end
			MODE_PSLLH, MODE_PSRLH, MODE_PSRAH: begin
				ctl.cls    = CLS_PH;
				ctl.amt_lo = {4'b0000, shift_field[3:0]};
				ctl.amt_hi = {1'b0, shift_field[3:0]};
			end
			MODE_PSLLW, MODE_PSRLW, MODE_PSRAW: begin
				ctl.cls    = CLS_PW;
				ctl.amt_lo = {3'b000, shift_field};
				ctl.amt_hi = shift_field;
			end
			MODE_PSLLVW, MODE_PSRLVW, MODE_PSRAVW: begin
				ctl.cls    = CLS_PVW;
				ctl.amt_lo = {3'b000, rs_low_amt[4:0]};
				ctl.amt_hi = rs_high_amt;
			end
			MODE_QFSRV: begin
				ctl.cls    = CLS_FUN;
				ctl.amt_lo = sa_amount;
			end
			default: begin
			end
		endcase

		unique case (mode) inside
			MODE_DSLL, MODE_DSLL32, MODE_DSLLV, MODE_SLL, MODE_SLLV,
			MODE_PSLLH, MODE_PSLLW, MODE_PSLLVW:
				ctl.kind = KIND_SLL;
			MODE_DSRA, MODE_DSRA32, MODE_DSRAV, MODE_SRA, MODE_SRAV,
			MODE_PSRAH, MODE_PSRAW, MODE_PSRAVW:
				ctl.kind = KIND_SRA;
			default:
				ctl.kind = KIND_SRL;
		endcase
	end

endmodule

// ===== design/csu_coarse.sv =====
// Coarse shift stage: shifts by whole bytes and registers the result (_s2).
// Depends on csu_pkg.
module csu_coarse (
	input  logic                    clk,
	input  logic                    en,
	input  csu_pkg::ctl_t           ctl_s1,
	input  logic [127:0]            rt_s1,
	input  logic [127:0]            rs_s1,
	output csu_pkg::ctl_t           ctl_s2,
	output logic [csu_pkg::FUN_W-1:0] data_s2
);
	import csu_pkg::*;

	logic [63:0]      lo_c;
	logic [63:0]      hi_c;
	logic [255:0]     fun_c;
	logic [FUN_W-1:0] data_c;

	always_comb begin
		lo_c  = lane_shift(rt_s1[63:0], ctl_s1.cls, ctl_s1.kind, {ctl_s1.amt_lo[5:3], 3'b000});
		hi_c  = lane_shift(rt_s1[127:64], ctl_s1.cls, ctl_s1.kind,
			{1'b0, ctl_s1.amt_hi[4:3], 3'b000});
		// Funnel: byte steps over the 256-bit {rs,rt}, keep a window for the bit step.
		fun_c = {rs_s1, rt_s1} >> {ctl_s1.amt_lo[7:3], 3'b000};
		if (ctl_s1.cls == CLS_FUN) begin
			data_c = fun_c[FUN_W-1:0];
		end else begin
			data_c = {{(FUN_W-128){1'b0}}, hi_c, lo_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2  <= ctl_s1;
			data_s2 <= data_c;
		end
	end

endmodule

// ===== design/csu_fine.sv =====
// Fine shift stage: bit steps, sign extension and result select (_s3).
// Depends on csu_pkg.
module csu_fine (
	input  logic                      clk,
	input  logic                      en,
	input  csu_pkg::ctl_t             ctl_s2,
	input  logic [csu_pkg::FUN_W-1:0] data_s2,
	output logic [63:0]               lo_s3,
	output logic [63:0]               hi_s3,
	output logic                      hw_s3
);
	import csu_pkg::*;

	logic [63:0]      lo_f;
	logic [63:0]      hi_f;
	logic [FUN_W-1:0] fun_f;
	logic [63:0]      lo_n;
	logic [63:0]      hi_n;
	logic             hw_n;

	always_comb begin
		lo_f  = lane_shift(data_s2[63:0], ctl_s2.cls, ctl_s2.kind, {3'b000, ctl_s2.amt_lo[2:0]});
		hi_f  = lane_shift(data_s2[127:64], ctl_s2.cls, ctl_s2.kind,
			{3'b000, ctl_s2.amt_hi[2:0]});
		fun_f = data_s2 >> ctl_s2.amt_lo[2:0];
		lo_n  = '0;
		hi_n  = '0;
		hw_n  = 1'b0;
		case (ctl_s2.cls) inside
			CLS_DW: lo_n = lo_f;
			CLS_W:  lo_n = {{32{lo_f[31]}}, lo_f[31:0]};
			CLS_PH, CLS_PW: begin
				lo_n = lo_f;
				hi_n = hi_f;
				hw_n = 1'b1;
			end
			CLS_PVW: begin
				lo_n = {{32{lo_f[31]}}, lo_f[31:0]};
				hi_n = {{32{hi_f[31]}}, hi_f[31:0]};
				hw_n = 1'b1;
			end
			CLS_FUN: begin
				lo_n = fun_f[63:0];
				hi_n = fun_f[127:64];
				hw_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3 <= lo_n;
			hi_s3 <= hi_n;
			hw_s3 <= hw_n;
		end
	end

endmodule

// ===== design/cpu_shift_unit_with_packed_lanes_core.sv =====
// Top level of the 128-bit shift unit: handshake, stage valid bits, stage 1.
// Depends on csu_pkg, csu_decode, csu_coarse and csu_fine.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------------
//   in      | in_valid / in_stall    | mode rt_low rt_high rs_low rs_high shift_field sa_amount
//   out     | out_valid / out_stall  | result_low result_high high_written
//
// Three register stages: decode (s1), byte-step shift (s2), bit-step shift and select (s3).
// One item enters per cycle while in_stall is low; it passes through s1, s2 and s3 in turn
// and is on the output once it reaches s3. Reset clears the stage valid bits only. in_stall
// is raised only when all three stages hold items and out_stall is high; a stall holds each
// full stage that has only full stages after it, moves the others on and drops nothing.
module cpu_shift_unit_with_packed_lanes_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  mode,
	input  logic [63:0] rt_low,
	input  logic [63:0] rt_high,
	input  logic [63:0] rs_low,
	input  logic [63:0] rs_high,
	input  logic [4:0]  shift_field,
	input  logic [7:0]  sa_amount,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_low,
	output logic [63:0] result_high,
	output logic        high_written
);
	import csu_pkg::*;

	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic             adv1;
	logic             adv2;
	logic             adv3;
	ctl_t             ctl_d;
	ctl_t             ctl_s1;
	ctl_t             ctl_s2;
	logic [127:0]     rt_s1;
	logic [127:0]     rs_s1;
	logic [FUN_W-1:0] data_s2;

	// A stage advances when it is empty or the stage after it advances.
	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	csu_decode u_decode (
		.mode        (mode),
		.shift_field (shift_field),
		.sa_amount   (sa_amount),
		.rs_low_amt  (rs_low[5:0]),
		.rs_high_amt (rs_high[4:0]),
		.ctl         (ctl_d)
	);

	// Capture the item and its decoded control.
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			ctl_s1 <= ctl_d;
			rt_s1  <= {rt_high, rt_low};
			rs_s1  <= {rs_high, rs_low};
		end
	end

	csu_coarse u_coarse (
		.clk     (clk),
		.en      (adv2 && valid_s1),
		.ctl_s1  (ctl_s1),
		.rt_s1   (rt_s1),
		.rs_s1   (rs_s1),
		.ctl_s2  (ctl_s2),
		.data_s2 (data_s2)
	);

	csu_fine u_fine (
		.clk     (clk),
		.en      (adv3 && valid_s2),
		.ctl_s2  (ctl_s2),
		.data_s2 (data_s2),
		.lo_s3   (result_low),
		.hi_s3   (result_high),
		.hw_s3   (high_written)
	);

	assign out_valid = valid_s3;

endmodule

// ===== design/csu_checker.sv =====
// Port-level checker for the shift unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module csu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [4:0]  mode,
	input logic [63:0] rt_low,
	input logic [63:0] rt_high,
	input logic [63:0] rs_low,
	input logic [63:0] rs_high,
	input logic [4:0]  shift_field,
	input logic [7:0]  sa_amount,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] result_low,
	input logic [63:0] result_high,
	input logic        high_written
);

	logic         out_held;
	logic [128:0] out_item;

	assign out_held = out_valid && out_stall;
	assign out_item = {high_written, result_high, result_low};

	// Input back-pressure only comes from a blocked output.
	`CSU_ASSERT(a_stall_from_out, !in_stall || out_held, "in_stall without blocked output")

	// An unwritten upper dword is delivered as zero.
	`CSU_ASSERT(a_high_zero, !out_valid || high_written || result_high == '0, "result_high not zero")

	`CSU_ASSERT_NEXT(a_out_hold, out_held, out_valid, "out_valid dropped under stall")

	`CSU_ASSERT_NEXT(a_out_stable, out_held, $stable(out_item), "stalled item changed")

endmodule

bind cpu_shift_unit_with_packed_lanes_core csu_checker u_csu_checker (.*);
